### sv/bpamm_pkg.sv
// ----------------------------------------------------------------------------
// Bump pool array memory manager package
// Shared constants: default sizes, operation codes and stream field widths.
// ----------------------------------------------------------------------------
package bpamm_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned GLOBAL_DEPTH_DEF  = 32;
  localparam int unsigned ARRAY_COUNT_DEF   = 8;
  localparam int unsigned ARRAY_MAX_LEN_DEF = 32;

  // Field widths of one input item and one result item.
  localparam int unsigned OP_W        = 3;
  localparam int unsigned ARRAY_W     = 8;
  localparam int unsigned POSITION_W  = 16;
  localparam int unsigned LENGTH_W    = 16;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned POOL_USED_W = 9;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 48;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_STORE_GLOBAL = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_GLOBAL  = 3'd1;
  localparam logic [OP_W-1:0] OP_CREATE_ARRAY = 3'd2;
  localparam logic [OP_W-1:0] OP_STORE_ELEM   = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD_ELEM    = 3'd4;
  localparam logic [OP_W-1:0] OP_FREE_ARRAY   = 3'd5;

endpackage

### sv/bpamm_pool_ram.sv
// ----------------------------------------------------------------------------
// Pool word memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module bpamm_pool_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/bump_pool_array_memory_manager.sv
// ----------------------------------------------------------------------------
// Bump pool array memory manager
// Global words plus bounds-checked arrays carved from one shared word pool.
// ----------------------------------------------------------------------------
// Each input item carries one of six operations: store or load a global word,
// create an array, store or load an element of an array, or free an array.
// Every item gives exactly one result item with an ok flag, the loaded word
// (zero unless a load succeeded) and the number of pool words allocated so
// far. Global words, array descriptors and pool words live in synchronous
// memories with a registered read: an item is accepted with its memory read,
// then checked and written back, and its result goes to the output register
// when that is free. An element load adds a pool read after the check, since the
// pool read can only start once the descriptor has been checked. A successful
// create then has the newly allocated region of the pool cleared
// through the single pool write port, one word per cycle. Arrays are bump
// allocated and the pool top never moves back, so a freed region can never be
// reached again and is not cleared; likewise pool words above the top are
// never read before a create clears them, so the pool needs no clearing pass
// after reset. The block takes one item at a time; a finished result waits in
// the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module bump_pool_array_memory_manager #(
  parameter int unsigned GLOBAL_DEPTH  = bpamm_pkg::GLOBAL_DEPTH_DEF,
  parameter int unsigned ARRAY_COUNT   = bpamm_pkg::ARRAY_COUNT_DEF,
  parameter int unsigned ARRAY_MAX_LEN = bpamm_pkg::ARRAY_MAX_LEN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input items.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, low bit up: array[7:0], position[23:8], length[39:24],
  // value[71:40].
  input  logic [bpamm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: operation[2:0].
  input  logic [bpamm_pkg::OP_W-1:0]          s_axis_tuser,
  // Result items.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, low bit up: read_value[31:0], pool_used[40:32], zero pad.
  output logic [bpamm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // tuser: ok.
  output logic                                m_axis_tuser
);

  import bpamm_pkg::*;

  localparam int unsigned POOL_SIZE = ARRAY_COUNT * ARRAY_MAX_LEN;
  localparam int unsigned GIDX_W    = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;
  localparam int unsigned AIDX_W    = (ARRAY_COUNT > 1) ? $clog2(ARRAY_COUNT) : 1;
  localparam int unsigned PADDR_W   = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned TOP_W     = $clog2(POOL_SIZE + 1);
  localparam int unsigned SIZE_W    = $clog2(ARRAY_MAX_LEN + 1);
  localparam int unsigned DESC_W    = PADDR_W + SIZE_W;
  localparam int unsigned SUM_W     = POSITION_W + 1;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_ZERO  = 3'd2;
  localparam logic [2:0] ST_PREAD = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0] state_q, state_d;

  // Unpacked input fields.
  logic [OP_W-1:0]       in_op;
  logic [ARRAY_W-1:0]    in_array;
  logic [POSITION_W-1:0] in_pos;
  logic [LENGTH_W-1:0]   in_len;
  logic [WORD_W-1:0]     in_val;
  logic                  in_fire;

  assign in_op    = s_axis_tuser;
  assign in_array = s_axis_tdata[7:0];
  assign in_pos   = s_axis_tdata[23:8];
  assign in_len   = s_axis_tdata[39:24];
  assign in_val   = s_axis_tdata[71:40];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // Item held while it is worked on.
  logic [OP_W-1:0]       op_q;
  logic [ARRAY_W-1:0]    id_q;
  logic [POSITION_W-1:0] pos_q;
  logic [LENGTH_W-1:0]   len_q;
  logic [WORD_W-1:0]     val_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= in_op;
      id_q  <= in_array;
      pos_q <= in_pos;
      len_q <= in_len;
      val_q <= in_val;
    end
  end

  // Global word memory; a word that was never stored reads as zero.
  logic [WORD_W-1:0]       gmem [GLOBAL_DEPTH];
  logic [WORD_W-1:0]       g_rdata_q;
  logic [GLOBAL_DEPTH-1:0] g_valid_q;
  logic                    g_rvalid_q;
  logic                    g_we;
  logic [GIDX_W-1:0]       g_ridx;
  logic [GIDX_W-1:0]       g_widx;

  assign g_ridx = in_pos[GIDX_W-1:0];
  assign g_widx = pos_q[GIDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      gmem[g_widx] <= val_q;
    end
    g_rdata_q <= gmem[g_ridx];
  end

  // Descriptor memory holds offset and size; the active bits are flip-flops
  // so that reset marks every array inactive at once.
  logic [DESC_W-1:0]      dmem [ARRAY_COUNT];
  logic [DESC_W-1:0]      d_rdata_q;
  logic [ARRAY_COUNT-1:0] active_q;
  logic                   d_ractive_q;
  logic                   d_we;
  logic [DESC_W-1:0]      d_wdata;
  logic [AIDX_W-1:0]      d_ridx;
  logic [AIDX_W-1:0]      d_widx;
  logic                   act_set;
  logic                   act_clr;

  assign d_ridx = in_array[AIDX_W-1:0];
  assign d_widx = id_q[AIDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      dmem[d_widx] <= d_wdata;
    end
    d_rdata_q <= dmem[d_ridx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q   <= '0;
      active_q    <= '0;
      g_rvalid_q  <= 1'b0;
      d_ractive_q <= 1'b0;
    end else begin
      if (g_we) begin
        g_valid_q[g_widx] <= 1'b1;
      end
      if (act_set) begin
        active_q[d_widx] <= 1'b1;
      end else if (act_clr) begin
        active_q[d_widx] <= 1'b0;
      end
      if (in_fire) begin
        g_rvalid_q  <= g_valid_q[g_ridx];
        d_ractive_q <= active_q[d_ridx];
      end
    end
  end

  // Pool memory.
  logic               p_we;
  logic [PADDR_W-1:0] p_waddr;
  logic [WORD_W-1:0]  p_wdata;
  logic [PADDR_W-1:0] p_raddr;
  logic [WORD_W-1:0]  p_rdata;

  bpamm_pool_ram #(
    .DEPTH  (POOL_SIZE),
    .ADDR_W (PADDR_W),
    .DATA_W (WORD_W)
  ) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // Pool top and the clearing walk of a new region.
  logic [TOP_W-1:0]   top_q, top_d;
  logic [PADDR_W-1:0] zaddr_q, zaddr_d;
  logic [SIZE_W-1:0]  zleft_q, zleft_d;

  // Result staging and output register.
  logic                   res_ok_q, res_ok_d;
  logic [WORD_W-1:0]      res_rd_q, res_rd_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_ok_q, out_ok_d;
  logic [WORD_W-1:0]      out_rd_q, out_rd_d;
  logic [POOL_USED_W-1:0] out_top_q, out_top_d;
  logic                   out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  // Checks made in the lookup cycle.
  logic [PADDR_W-1:0] d_offset;
  logic [SIZE_W-1:0]  d_size;
  logic               g_in_range;
  logic               id_ok;
  logic               len_ok;
  logic               fits;
  logic               elem_ok;
  logic [SUM_W-1:0]   slot_sum;
  logic [SUM_W-1:0]   top_sum;

  assign d_offset   = d_rdata_q[DESC_W-1:SIZE_W];
  assign d_size     = d_rdata_q[SIZE_W-1:0];
  assign g_in_range = pos_q < POSITION_W'(GLOBAL_DEPTH);
  assign id_ok      = id_q < ARRAY_W'(ARRAY_COUNT);
  assign len_ok     = (len_q != '0) && (len_q <= LENGTH_W'(ARRAY_MAX_LEN));
  assign top_sum    = SUM_W'(top_q) + SUM_W'(len_q);
  assign fits       = top_sum <= SUM_W'(POOL_SIZE);
  assign slot_sum   = SUM_W'(d_offset) + SUM_W'(pos_q);
  assign elem_ok    = id_ok && d_ractive_q && (pos_q < POSITION_W'(d_size)) &&
                      (slot_sum < SUM_W'(POOL_SIZE));

  always_comb begin
    logic              fin;
    logic              fin_ok;
    logic [WORD_W-1:0] fin_rd;

    fin      = 1'b0;
    fin_ok   = 1'b0;
    fin_rd   = '0;
    state_d  = state_q;
    top_d    = top_q;
    zaddr_d  = zaddr_q;
    zleft_d  = zleft_q;
    res_ok_d = res_ok_q;
    res_rd_d = res_rd_q;
    g_we     = 1'b0;
    d_we     = 1'b0;
    d_wdata  = {PADDR_W'(top_q), len_q[SIZE_W-1:0]};
    act_set  = 1'b0;
    act_clr  = 1'b0;
    p_we     = 1'b0;
    p_waddr  = slot_sum[PADDR_W-1:0];
    p_wdata  = val_q;
    p_raddr  = slot_sum[PADDR_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        case (op_q)
          OP_STORE_GLOBAL: begin
            fin    = 1'b1;
            fin_ok = g_in_range;
            g_we   = g_in_range;
          end
          OP_LOAD_GLOBAL: begin
            fin    = 1'b1;
            fin_ok = g_in_range;
            fin_rd = (g_in_range && g_rvalid_q) ? g_rdata_q : '0;
          end
          OP_CREATE_ARRAY: begin
            if (id_ok && len_ok && !d_ractive_q && fits) begin
              d_we    = 1'b1;
              act_set = 1'b1;
              top_d   = TOP_W'(top_sum);
              zaddr_d = PADDR_W'(top_q);
              zleft_d = len_q[SIZE_W-1:0];
              state_d = ST_ZERO;
            end else begin
              fin = 1'b1;
            end
          end
          OP_STORE_ELEM: begin
            fin    = 1'b1;
            fin_ok = elem_ok;
            p_we   = elem_ok;
          end
          OP_LOAD_ELEM: begin
            if (elem_ok) begin
              state_d = ST_PREAD;
            end else begin
              fin = 1'b1;
            end
          end
          OP_FREE_ARRAY: begin
            fin     = 1'b1;
            fin_ok  = id_ok && d_ractive_q;
            act_clr = id_ok && d_ractive_q;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_ZERO: begin
        p_we    = 1'b1;
        p_waddr = zaddr_q;
        p_wdata = '0;
        zaddr_d = zaddr_q + 1'b1;
        zleft_d = zleft_q - 1'b1;
        if (zleft_q == SIZE_W'(1)) begin
          fin    = 1'b1;
          fin_ok = 1'b1;
        end
      end
      ST_PREAD: begin
        fin    = 1'b1;
        fin_ok = 1'b1;
        fin_rd = p_rdata;
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A finished result goes straight to the output register when it is free,
    // otherwise it waits in the staging register. The pool top is taken along
    // with the result, since the next item may move it while the result waits.
    out_valid_d = out_valid_q && !m_axis_tready;
    out_ok_d    = out_ok_q;
    out_rd_d    = out_rd_q;
    out_top_d   = out_top_q;
    if (fin) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_ok_d    = fin_ok;
        out_rd_d    = fin_rd;
        out_top_d   = POOL_USED_W'(top_q);
        state_d     = ST_IDLE;
      end else begin
        res_ok_d = fin_ok;
        res_rd_d = fin_rd;
        state_d  = ST_RESP;
      end
    end else if ((state_q == ST_RESP) && out_free) begin
      out_valid_d = 1'b1;
      out_ok_d    = res_ok_q;
      out_rd_d    = res_rd_q;
      out_top_d   = POOL_USED_W'(top_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zaddr_q   <= zaddr_d;
    zleft_q   <= zleft_d;
    res_ok_q  <= res_ok_d;
    res_rd_q  <= res_rd_d;
    out_ok_q  <= out_ok_d;
    out_rd_q  <= out_rd_d;
    out_top_q <= out_top_d;
  end

  // The pool top in a result is the one after its own item, held in the
  // output register together with the other result fields.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - WORD_W - POOL_USED_W)'(0),
                          out_top_q, out_rd_q};

endmodule

### tb/sv/bump_pool_array_memory_manager_tb.sv
// ----------------------------------------------------------------------------
// Bump pool array memory manager testbench
// Drives items into the block with random gaps and back pressure, predicts
// each result item from its own copy of the globals, descriptors and pool,
// and checks every result item field by field in order of arrival.
// ----------------------------------------------------------------------------
module bump_pool_array_memory_manager_tb;
  import bpamm_pkg::*;

  localparam int unsigned NUM_GLOBALS   = GLOBAL_DEPTH_DEF;
  localparam int unsigned NUM_ARRAYS    = ARRAY_COUNT_DEF;
  localparam int unsigned MAX_ARRAY_LEN = ARRAY_MAX_LEN_DEF;
  localparam int unsigned POOL_WORDS    = NUM_ARRAYS * MAX_ARRAY_LEN;
  localparam int unsigned RANDOM_ITEMS  = 1575;
  // Cycles without any handshake before the run is declared hung. The slowest
  // item is a full-length create, which clears its whole region.
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned TAIL_CYCLES   = 64;

  // One input item as the sender sees it.
  typedef struct {
    logic [OP_W-1:0]          op;
    logic [ARRAY_W-1:0]       id;
    logic [POSITION_W-1:0]    pos;
    logic [LENGTH_W-1:0]      len;
    logic signed [WORD_W-1:0] value;
  } mem_request_t;

  // One result item.
  typedef struct {
    logic                     ok;
    logic signed [WORD_W-1:0] read_value;
    logic [POOL_USED_W-1:0]   pool_used;
  } mem_result_t;

  // Keeps a private image of the memory unit, works out the result of every
  // accepted item and compares the result items against it in order.
  class pool_scoreboard;
    logic [WORD_W-1:0] global_words [NUM_GLOBALS];
    bit                arr_active   [NUM_ARRAYS];
    int unsigned       arr_base     [NUM_ARRAYS];
    int unsigned       arr_size     [NUM_ARRAYS];
    logic [WORD_W-1:0] pool_words   [POOL_WORDS];
    int unsigned       pool_top;
    mem_result_t       pending_results [$];
    int unsigned       errors;

    function new();
      foreach (global_words[i]) global_words[i] = '0;
      foreach (arr_active[i]) begin
        arr_active[i] = 1'b0;
        arr_base[i]   = 0;
        arr_size[i]   = 0;
      end
      foreach (pool_words[i]) pool_words[i] = '0;
      pool_top = 0;
      errors   = 0;
    endfunction

    function bit element_ok(logic [ARRAY_W-1:0] id, logic [POSITION_W-1:0] pos);
      if (id >= NUM_ARRAYS) return 1'b0;
      if (!arr_active[id]) return 1'b0;
      return pos < arr_size[id];
    endfunction

    // An item was accepted: update the image and queue the result it gives.
    function void note_item(logic [OP_W-1:0] op, logic [ARRAY_W-1:0] id,
                            logic [POSITION_W-1:0] pos, logic [LENGTH_W-1:0] len,
                            logic [WORD_W-1:0] value);
      mem_result_t res;
      res.ok         = 1'b0;
      res.read_value = '0;
      case (op)
        OP_STORE_GLOBAL: begin
          if (pos < NUM_GLOBALS) begin
            global_words[pos] = value;
            res.ok = 1'b1;
          end
        end
        OP_LOAD_GLOBAL: begin
          if (pos < NUM_GLOBALS) begin
            res.read_value = global_words[pos];
            res.ok = 1'b1;
          end
        end
        OP_CREATE_ARRAY: begin
          if (id < NUM_ARRAYS && len != 0 && len <= MAX_ARRAY_LEN &&
              !arr_active[id] && pool_top + len <= POOL_WORDS) begin
            arr_active[id] = 1'b1;
            arr_base[id]   = pool_top;
            arr_size[id]   = 32'(len);
            for (int unsigned k = 0; k < len; k++) pool_words[pool_top + k] = '0;
            pool_top += 32'(len);
            res.ok = 1'b1;
          end
        end
        OP_STORE_ELEM: begin
          if (element_ok(id, pos)) begin
            pool_words[arr_base[id] + pos] = value;
            res.ok = 1'b1;
          end
        end
        OP_LOAD_ELEM: begin
          if (element_ok(id, pos)) begin
            res.read_value = pool_words[arr_base[id] + pos];
            res.ok = 1'b1;
          end
        end
        OP_FREE_ARRAY: begin
          if (id < NUM_ARRAYS && arr_active[id]) begin
            for (int unsigned k = 0; k < arr_size[id]; k++)
              pool_words[arr_base[id] + k] = '0;
            arr_active[id] = 1'b0;
            arr_base[id]   = 0;
            arr_size[id]   = 0;
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
      res.pool_used = pool_top[POOL_USED_W-1:0];
      pending_results.push_back(res);
    endfunction

    // A result item was accepted: compare it with the oldest expectation.
    function void check_result(logic ok, logic [WORD_W-1:0] read_value,
                               logic [POOL_USED_W-1:0] pool_used);
      mem_result_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item ok=%0b read_value=%0d pool_used=%0d",
                 $time, ok, $signed(read_value), pool_used);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (ok !== exp_res.ok) begin
        $display("%0t: ok mismatch, expected %0b, actual %0b", $time, exp_res.ok, ok);
        errors++;
      end
      if (read_value !== exp_res.read_value) begin
        $display("%0t: read_value mismatch, expected %0d, actual %0d",
                 $time, exp_res.read_value, $signed(read_value));
        errors++;
      end
      if (pool_used !== exp_res.pool_used) begin
        $display("%0t: pool_used mismatch, expected %0d, actual %0d",
                 $time, exp_res.pool_used, pool_used);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata, low bit up: array, position, length, value.
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // tuser: operation.
  logic [OP_W-1:0]        s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata, low bit up: read_value, pool_used, zero pad.
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // tuser: ok.
  logic                   m_axis_tuser;

  // Random idling on both sides is switched off for one long stretch.
  bit          idle_on     = 1'b1;
  int unsigned quiet_count = 0;
  pool_scoreboard sb = new();

  bump_pool_array_memory_manager dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: stalls about 9 percent of the time while idling is on.
  always @(posedge clk_i) begin
    m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= 9);
  end

  // Both handshakes are sampled here, with the values from before the edge,
  // so neither the block's nor the driver's updates at this edge can race.
  // The watchdog counts edges at which neither side moved an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8],
                     s_axis_tdata[39:24], s_axis_tdata[71:40]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[40:32]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_count = 0;
      else
        quiet_count++;
      if (quiet_count >= STALL_LIMIT) begin
        $display("bump_pool_array_memory_manager verification failed");
        $finish;
      end
    end
  end

  function automatic mem_request_t make_request(logic [OP_W-1:0] op,
                                                logic [ARRAY_W-1:0] id,
                                                logic [POSITION_W-1:0] pos,
                                                logic [LENGTH_W-1:0] len,
                                                logic [WORD_W-1:0] value);
    mem_request_t req;
    req.op    = op;
    req.id    = id;
    req.pos   = pos;
    req.len   = len;
    req.value = value;
    return req;
  endfunction

  // Picks an array id, leaning toward one whose active flag matches want_active
  // so that element accesses mostly hit live arrays and creates free slots.
  function automatic logic [ARRAY_W-1:0] pick_array(bit want_active);
    logic [ARRAY_W-1:0] id;
    if ($urandom_range(0, 9) == 0) return ARRAY_W'($urandom_range(0, 255));
    id = ARRAY_W'($urandom_range(0, NUM_ARRAYS - 1));
    for (int tries = 0; tries < 8; tries++) begin
      if (sb.arr_active[id] == want_active) return id;
      id = ARRAY_W'($urandom_range(0, NUM_ARRAYS - 1));
    end
    return id;
  endfunction

  // Random item. Most element accesses land inside a live array; the rest
  // probe the boundary or go far out. Lengths are kept short so that the
  // pool, which never shrinks, lasts most of the run; at the end it is
  // pushed toward full with maximal lengths.
  function automatic mem_request_t random_request(bit fill_pool);
    mem_request_t req;
    int unsigned  roll;
    req.value = $urandom();
    req.len   = LENGTH_W'($urandom_range(0, 65535));
    req.pos   = POSITION_W'($urandom_range(0, 65535));
    req.id    = ARRAY_W'($urandom_range(0, 255));
    roll      = $urandom_range(0, 99);
    if (roll < 12 || (roll >= 96 && roll < 98)) begin
      req.op = (roll < 6) ? OP_STORE_GLOBAL : OP_LOAD_GLOBAL;
      if ($urandom_range(0, 99) < 85)
        req.pos = POSITION_W'($urandom_range(0, NUM_GLOBALS - 1));
    end else if (roll < 24) begin
      req.op = OP_CREATE_ARRAY;
      req.id = pick_array(1'b0);
      if ($urandom_range(0, 19) == 0)
        req.len = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(33, 65535));
      else if (fill_pool || $urandom_range(0, 11) == 0)
        req.len = fill_pool ? LENGTH_W'(MAX_ARRAY_LEN)
                            : LENGTH_W'($urandom_range(1, MAX_ARRAY_LEN));
      else
        req.len = LENGTH_W'($urandom_range(1, 3));
    end else if (roll < 92) begin
      req.op = (roll < 52) ? OP_STORE_ELEM : OP_LOAD_ELEM;
      req.id = pick_array(1'b1);
      if (req.id < NUM_ARRAYS && sb.arr_active[req.id] && $urandom_range(0, 99) < 85)
        req.pos = POSITION_W'($urandom_range(0, sb.arr_size[req.id] - 1));
      else if (req.id < NUM_ARRAYS && $urandom_range(0, 1) == 0)
        req.pos = POSITION_W'(sb.arr_size[req.id]);
    end else if (roll < 96) begin
      req.op = OP_FREE_ARRAY;
      req.id = pick_array(1'b1);
    end else begin
      // Noise: unused codes or any code with fully random fields.
      req.op = (roll < 99) ? OP_W'($urandom_range(6, 7)) : OP_W'($urandom_range(0, 7));
    end
    return req;
  endfunction

  // Presents one item and returns at the edge where it is taken. tvalid stays
  // high afterwards, so back-to-back items need no second assignment.
  task automatic send_item(input mem_request_t req);
    while (idle_on && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.op;
    s_axis_tdata  <= {req.value, req.len, req.pos, req.id};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Holds the sender off until every queued result has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_results.size() != 0);
  endtask

  initial begin
    mem_request_t directed [$];
    int unsigned  quiet_start;

    // Word extremes on the globals, then the rejection paths but a full pool, then
    // a full length array with its top element written and read back, and accesses
    // to arrays that are inactive, unknown or already freed.
    directed.push_back(make_request(OP_STORE_GLOBAL, 8'd0, 16'd0, 16'd0, 32'h7fff_ffff));
    directed.push_back(make_request(OP_STORE_GLOBAL, 8'd0, 16'd31, 16'hffff, 32'h8000_0000));
    directed.push_back(make_request(OP_LOAD_GLOBAL, 8'd0, 16'd0, 16'd0, 32'd0));
    directed.push_back(make_request(OP_LOAD_GLOBAL, 8'hff, 16'd31, 16'd0, 32'hffff_ffff));
    directed.push_back(make_request(OP_STORE_GLOBAL, 8'd0, 16'd32, 16'd0, 32'h1234_5678));
    directed.push_back(make_request(OP_LOAD_GLOBAL, 8'd0, 16'hffff, 16'd0, 32'd0));
    directed.push_back(make_request(OP_CREATE_ARRAY, 8'd0, 16'd0, 16'd0, 32'd0));
    directed.push_back(make_request(OP_CREATE_ARRAY, 8'd0, 16'd0, 16'd33, 32'd0));
    directed.push_back(make_request(OP_CREATE_ARRAY, 8'd8, 16'd0, 16'd4, 32'd0));
    directed.push_back(make_request(OP_CREATE_ARRAY, 8'hff, 16'hffff, 16'hffff, 32'd0));
    directed.push_back(make_request(OP_CREATE_ARRAY, 8'd0, 16'd0, 16'd32, 32'd0));
    directed.push_back(make_request(OP_CREATE_ARRAY, 8'd0, 16'd0, 16'd1, 32'd0));
    directed.push_back(make_request(OP_CREATE_ARRAY, 8'd7, 16'd0, 16'd1, 32'd0));
    directed.push_back(make_request(OP_LOAD_ELEM, 8'd0, 16'd0, 16'd0, 32'd0));
    directed.push_back(make_request(OP_STORE_ELEM, 8'd0, 16'd31, 16'd0, 32'hffff_ffff));
    directed.push_back(make_request(OP_LOAD_ELEM, 8'd0, 16'd31, 16'd0, 32'd0));
    directed.push_back(make_request(OP_STORE_ELEM, 8'd0, 16'd32, 16'd0, 32'h5555_aaaa));
    directed.push_back(make_request(OP_LOAD_ELEM, 8'd3, 16'd0, 16'd0, 32'd0));
    directed.push_back(make_request(OP_LOAD_ELEM, 8'd8, 16'd0, 16'd0, 32'd0));
    directed.push_back(make_request(OP_FREE_ARRAY, 8'd7, 16'd0, 16'd0, 32'd0));
    directed.push_back(make_request(OP_FREE_ARRAY, 8'd7, 16'd0, 16'd0, 32'd0));
    directed.push_back(make_request(OP_FREE_ARRAY, 8'd200, 16'd0, 16'd0, 32'd0));
    directed.push_back(make_request(OP_W'(6), 8'd0, 16'd0, 16'd1, 32'd0));
    directed.push_back(make_request(OP_W'(7), 8'd1, 16'd1, 16'd1, 32'hffff_ffff));
    directed.push_back(make_request(OP_LOAD_ELEM, 8'd7, 16'd0, 16'd0, 32'd0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_item(directed[i]);
    wait_for_results();

    quiet_start = $urandom_range(300, 700);
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= quiet_start && n < quiet_start + 300);
      if (n != 0 && n % 250 == 0) wait_for_results();
      send_item(random_request(n >= RANDOM_ITEMS - 150));
    end

    idle_on = 1'b1;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("bump_pool_array_memory_manager verification clean");
    else
      $display("bump_pool_array_memory_manager verification failed");
    $finish;
  end

endmodule
